// ----- hw/rtl/ccpe_pkg.sv -----
// Shared types and constants of the cubic curve point evaluator.
package ccpe_pkg;

  // Width of one output coordinate in signed Q20.4.
  localparam int OUT_W = 24;

  // Width of the configuration register index.
  localparam int CFG_IDX_W = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_index_t;

  // Configuration register indexes.
  localparam cfg_index_t CFG_CURVE_MODE = 3'd0;
  localparam cfg_index_t CFG_POINT_A    = 3'd1;
  localparam cfg_index_t CFG_POINT_B    = 3'd2;
  localparam cfg_index_t CFG_POINT_C    = 3'd3;
  localparam cfg_index_t CFG_POINT_D    = 3'd4;

  // Curve kinds selected by the mode register.
  typedef enum logic [2:0] {
    MODE_BEZIER        = 3'd0,
    MODE_BEZIER_SLOPE  = 3'd1,
    MODE_BSPLINE       = 3'd2,
    MODE_BSPLINE_SLOPE = 3'd3,
    MODE_HERMITE       = 3'd4,
    MODE_HERMITE_SLOPE = 3'd5
  } curve_mode_t;

  // Saturation rails of an output coordinate.
  localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7FFFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 24'sh800000;

endpackage

// ----- hw/rtl/ccpe_basis.sv -----
// Three pipeline stages that clamp t and form the powers of t and u = 1 - t.
module ccpe_basis #(
  parameter int T_FRAC_BITS = 16,
  localparam int TW = T_FRAC_BITS + 1,
  localparam int PW = 2 * T_FRAC_BITS + 1,
  localparam int QW = 3 * T_FRAC_BITS + 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [TW-1:0] in_t,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [TW-1:0] out_t,
  output logic [PW-1:0] out_t2,
  output logic [PW-1:0] out_u2,
  output logic [PW-1:0] out_ut,
  output logic [QW-1:0] out_t3,
  output logic [QW-1:0] out_u3,
  output logic [QW-1:0] out_u2t,
  output logic [QW-1:0] out_ut2
);

  localparam logic [TW-1:0] ONE = TW'(1) << T_FRAC_BITS;

  logic          va, vb, vc;
  logic          ena, enb, enc;
  logic [TW-1:0] t_a, u_a, t_b, u_b;
  logic [PW-1:0] t2, u2, ut;

  // Each stage moves when it is empty or the next one moves.
  assign enc      = !vc || out_ready;
  assign enb      = !vb || enc;
  assign ena      = !va || enb;
  assign in_ready = ena;

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      if (ena) va <= in_valid;
      if (enb) vb <= va;
      if (enc) vc <= vb;
    end
  end

  // Stage A: clamp t to 1.0 and form u.
  always_ff @(posedge clk) begin
    if (ena) begin
      t_a <= (in_t > ONE) ? ONE : in_t;
      u_a <= ONE - ((in_t > ONE) ? ONE : in_t);
    end
  end

  // Stage B: second-order products.
  always_ff @(posedge clk) begin
    if (enb) begin
      t_b <= t_a;
      u_b <= u_a;
      t2  <= PW'(t_a) * PW'(t_a);
      u2  <= PW'(u_a) * PW'(u_a);
      ut  <= PW'(u_a) * PW'(t_a);
    end
  end

  // Stage C: third-order products.
  always_ff @(posedge clk) begin
    if (enc) begin
      out_t   <= t_b;
      out_t2  <= t2;
      out_u2  <= u2;
      out_ut  <= ut;
      out_t3  <= QW'(t2) * QW'(t_b);
      out_u3  <= QW'(u2) * QW'(u_b);
      out_u2t <= QW'(u2) * QW'(t_b);
      out_ut2 <= QW'(ut) * QW'(t_b);
    end
  end

  assign out_valid = vc;

  // The clamp keeps t squared at or below one.
  a_t2_clamped: assert property (@(posedge clk) disable iff (rst)
    vb |-> t2 <= (PW'(1) << (2 * T_FRAC_BITS)))
    else $error("t squared exceeds one after clamping");

endmodule

// ----- hw/rtl/ccpe_weights.sv -----
// Three pipeline stages that turn the powers of t into the four rounded blend weights.
module ccpe_weights #(
  parameter int T_FRAC_BITS = 16,
  localparam int TW = T_FRAC_BITS + 1,
  localparam int PW = 2 * T_FRAC_BITS + 1,
  localparam int QW = 3 * T_FRAC_BITS + 1,
  localparam int WW = T_FRAC_BITS + 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ccpe_pkg::curve_mode_t mode,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [TW-1:0]         in_t,
  input  logic [PW-1:0]         in_t2,
  input  logic [PW-1:0]         in_u2,
  input  logic [PW-1:0]         in_ut,
  input  logic [QW-1:0]         in_t3,
  input  logic [QW-1:0]         in_u3,
  input  logic [QW-1:0]         in_u2t,
  input  logic [QW-1:0]         in_ut2,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [3:0][WW-1:0]    out_w
);

  import ccpe_pkg::*;

  localparam int F  = T_FRAC_BITS;
  localparam int NW = 3 * T_FRAC_BITS + 5;
  // Reciprocal of three for quotients below 2^(F+2).
  localparam int K  = T_FRAC_BITS + 4;
  localparam int QM = T_FRAC_BITS + 2 + K;
  localparam logic [K-1:0] RECIP = K'((2 ** K) / 3 + 1);

  localparam logic signed [NW-1:0] C2 = NW'(2);
  localparam logic signed [NW-1:0] C3 = NW'(3);
  localparam logic signed [NW-1:0] C4 = NW'(4);
  localparam logic signed [NW-1:0] C6 = NW'(6);
  localparam logic signed [NW-1:0] S2 = NW'(1) << (2 * F);
  localparam logic signed [NW-1:0] S3 = NW'(1) << (3 * F);
  localparam logic signed [NW-1:0] HALF_S  = NW'(1) << (F - 1);
  localparam logic signed [NW-1:0] HALF_S2 = NW'(1) << (2 * F - 1);
  localparam logic signed [NW-1:0] HALF_2S = NW'(1) << F;
  localparam logic signed [NW-1:0] HALF_6S2 = NW'(3) << (2 * F);

  logic                 vd, ve, vf;
  logic                 end_, ene, enf;
  logic signed [NW-1:0] n_next [4];
  logic signed [NW-1:0] n_d    [4];
  logic signed [WW-1:0] w_next [4];
  logic signed [WW-1:0] w_e    [4];
  logic signed [WW-1:0] w_f    [4];

  assign enf      = !vf || out_ready;
  assign ene      = !ve || enf;
  assign end_     = !vd || ene;
  assign in_ready = end_;

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
      ve <= 1'b0;
      vf <= 1'b0;
    end else begin
      if (end_) vd <= in_valid;
      if (ene)  ve <= vd;
      if (enf)  vf <= ve;
    end
  end

  // Basis numerators of the selected curve kind, exact in integers.
  always_comb begin
    logic signed [NW-1:0] et, et2, eu2, eut, et3, eu3, eu2t, eut2, st, st2;
    et   = $signed(NW'(in_t));
    et2  = $signed(NW'(in_t2));
    eu2  = $signed(NW'(in_u2));
    eut  = $signed(NW'(in_ut));
    et3  = $signed(NW'(in_t3));
    eu3  = $signed(NW'(in_u3));
    eu2t = $signed(NW'(in_u2t));
    eut2 = $signed(NW'(in_ut2));
    st   = et <<< F;
    st2  = et2 <<< F;
    case (mode)
      MODE_BEZIER: begin
        n_next[0] = eu3;
        n_next[1] = C3 * eu2t;
        n_next[2] = C3 * eut2;
        n_next[3] = et3;
      end
      MODE_BEZIER_SLOPE: begin
        n_next[0] = -(C3 * eu2);
        n_next[1] = C3 * eu2 - C6 * eut;
        n_next[2] = C6 * eut - C3 * et2;
        n_next[3] = C3 * et2;
      end
      MODE_BSPLINE: begin
        n_next[0] = eu3;
        n_next[1] = C3 * et3 - C6 * st2 + C4 * S3;
        n_next[2] = C3 * st2 + C3 * (et <<< (2 * F)) + S3 - C3 * et3;
        n_next[3] = et3;
      end
      MODE_BSPLINE_SLOPE: begin
        n_next[0] = -eu2;
        n_next[1] = C3 * et2 - C4 * st;
        n_next[2] = C2 * st + S2 - C3 * et2;
        n_next[3] = et2;
      end
      MODE_HERMITE: begin
        n_next[0] = C2 * et3 - C3 * st2 + S3;
        n_next[1] = C3 * st2 - C2 * et3;
        n_next[2] = eu2t;
        n_next[3] = et3 - st2;
      end
      MODE_HERMITE_SLOPE: begin
        n_next[0] = C6 * et2 - C6 * st;
        n_next[1] = C6 * st - C6 * et2;
        n_next[2] = C3 * et2 - C4 * st + S2;
        n_next[3] = C3 * et2 - C2 * st;
      end
      default: begin
        for (int i = 0; i < 4; i++) n_next[i] = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (end_) n_d <= n_next;
  end

  // Round to nearest by the basis denominator. B-spline points leave a
  // quotient by 2S^2 here, still to be divided by three.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      case (mode)
        MODE_BEZIER, MODE_HERMITE:
          w_next[i] = WW'((n_d[i] + HALF_S2) >>> (2 * F));
        MODE_BSPLINE:
          w_next[i] = WW'((n_d[i] + HALF_6S2) >>> (2 * F + 1));
        MODE_BSPLINE_SLOPE:
          w_next[i] = WW'((n_d[i] + HALF_2S) >>> (F + 1));
        default:
          w_next[i] = WW'((n_d[i] + HALF_S) >>> F);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ene) w_e <= w_next;
  end

  // Exact divide by three through the reciprocal for B-spline points.
  always_ff @(posedge clk) begin
    if (enf) begin
      for (int i = 0; i < 4; i++) begin
        if (mode == MODE_BSPLINE) begin
          w_f[i] <= $signed(WW'((QM'(w_e[i][F+1:0]) * QM'(RECIP)) >> K));
        end else begin
          w_f[i] <= w_e[i];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) out_w[i] = w_f[i];
  end

  assign out_valid = vf;

endmodule

// ----- hw/rtl/ccpe_blend.sv -----
// Three pipeline stages that weight the control coordinates, sum, round and saturate.
module ccpe_blend #(
  parameter int COORD_BITS  = 16,
  parameter int T_FRAC_BITS = 16,
  localparam int WW = T_FRAC_BITS + 3
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [3:0][3*COORD_BITS-1:0]      points,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [3:0][WW-1:0]                in_w,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ccpe_pkg::OUT_W-1:0] out_x,
  output logic signed [ccpe_pkg::OUT_W-1:0] out_y,
  output logic signed [ccpe_pkg::OUT_W-1:0] out_z,
  output logic                              out_sat
);

  import ccpe_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int F   = T_FRAC_BITS;
  localparam int PRW = CB + WW;
  localparam int AW  = PRW + 2;
  localparam int SH  = F - 4;
  localparam int SW  = AW - SH;
  localparam int CW  = (SW > OUT_W) ? SW : OUT_W + 1;
  localparam logic signed [AW-1:0] ROUND_BIAS = AW'(1) << (SH - 1);

  logic                  vg, vh, vi;
  logic                  eng, enh, eni;
  logic signed [PRW-1:0] prod [3][4];
  logic signed [AW-1:0]  acc  [3];
  logic signed [OUT_W-1:0] res_next [3];
  logic                  sat_next;

  assign eni      = !vi || out_ready;
  assign enh      = !vh || eni;
  assign eng      = !vg || enh;
  assign in_ready = eng;

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vg <= 1'b0;
      vh <= 1'b0;
      vi <= 1'b0;
    end else begin
      if (eng) vg <= in_valid;
      if (enh) vh <= vg;
      if (eni) vi <= vh;
    end
  end

  // Stage G: one product per axis and control vector.
  always_ff @(posedge clk) begin
    if (eng) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 4; i++) begin
          prod[k][i] <= PRW'($signed(points[i][k*CB +: CB])) * PRW'($signed(in_w[i]));
        end
      end
    end
  end

  // Stage H: sum the four products with the rounding bias.
  always_ff @(posedge clk) begin
    if (enh) begin
      for (int k = 0; k < 3; k++) begin
        acc[k] <= AW'(prod[k][0]) + AW'(prod[k][1]) + AW'(prod[k][2]) + AW'(prod[k][3])
                  + ROUND_BIAS;
      end
    end
  end

  // Stage I: drop the extra fraction bits and clamp to Q20.4.
  always_comb begin
    logic signed [SW-1:0] sh;
    logic signed [CW-1:0] ext;
    sat_next = 1'b0;
    for (int k = 0; k < 3; k++) begin
      sh  = $signed(acc[k][AW-1:SH]);
      ext = CW'(sh);
      if (ext > CW'(OUT_MAX)) begin
        res_next[k] = OUT_MAX;
        sat_next    = 1'b1;
      end else if (ext < CW'(OUT_MIN)) begin
        res_next[k] = OUT_MIN;
        sat_next    = 1'b1;
      end else begin
        res_next[k] = OUT_W'(ext);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (eni) begin
      out_x   <= res_next[0];
      out_y   <= res_next[1];
      out_z   <= res_next[2];
      out_sat <= sat_next;
    end
  end

  assign out_valid = vi;

  // A saturated result has at least one component on a rail.
  a_sat_on_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_sat |-> (out_x == OUT_MAX || out_x == OUT_MIN ||
                              out_y == OUT_MAX || out_y == OUT_MIN ||
                              out_z == OUT_MAX || out_z == OUT_MIN))
    else $error("saturated flag set with no component on a rail");

endmodule

// ----- hw/rtl/cubic_curve_point_evaluator_unit.sv -----
// Top level of the cubic curve point evaluator: configuration registers and pipeline.
//
// Usage: write curve_mode and the four control vectors through the cfg channel
// (cfg_index selects the register, cfg_data carries the value; cfg_ready is always
// high, unknown indexes are dropped). Then stream curve parameters t, unsigned
// Q1.T_FRAC_BITS, on the s_axis channel; values above 1.0 are taken as 1.0.
// Each accepted t yields one point or slope on m_axis: x, y and z in signed Q20.4,
// with the tuser bit set when any component was clamped to range.
// The pipeline has nine register stages: three form powers of t, three form the
// rounded blend weights, three multiply, sum and saturate. A result shows on
// m_axis_tvalid once it sits in the last of the nine registers; one transaction is
// accepted every cycle while s_axis_tready is high.
// Reset empties the pipeline and clears the configuration registers to zero (Bezier mode with
// all control points at the origin).
// When the receiver stalls, the result stays in the output register and earlier
// stages keep filling any empty slots; s_axis_tready drops only once every stage
// holds an item. Configuration must only change while the pipeline is empty.
module cubic_curve_point_evaluator_unit #(
  parameter int COORD_BITS  = 16,
  parameter int T_FRAC_BITS = 16,
  localparam int TIN_W = ((T_FRAC_BITS + 8) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ccpe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [3*COORD_BITS-1:0]         cfg_data,
  // Input stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [TIN_W-1:0]                s_axis_tdata,  // param_t, zero padded
  // Output stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [3*ccpe_pkg::OUT_W-1:0]    m_axis_tdata,  // out_x, out_y, out_z
  output logic [0:0]                      m_axis_tuser   // saturated
);

  import ccpe_pkg::*;

  localparam int TW = T_FRAC_BITS + 1;
  localparam int PW = 2 * T_FRAC_BITS + 1;
  localparam int QW = 3 * T_FRAC_BITS + 1;
  localparam int WW = T_FRAC_BITS + 3;

  curve_mode_t                     curve_mode;
  logic [3:0][3*COORD_BITS-1:0]    ctrl_pts;

  logic          b_valid, b_ready;
  logic [TW-1:0] b_t;
  logic [PW-1:0] b_t2, b_u2, b_ut;
  logic [QW-1:0] b_t3, b_u3, b_u2t, b_ut2;

  logic             w_valid, w_ready;
  logic [3:0][WW-1:0] w_val;

  logic signed [OUT_W-1:0] res_x, res_y, res_z;
  logic                    res_sat;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      curve_mode <= MODE_BEZIER;
      ctrl_pts   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CURVE_MODE: curve_mode  <= curve_mode_t'(cfg_data[2:0]);
        CFG_POINT_A:    ctrl_pts[0] <= cfg_data;
        CFG_POINT_B:    ctrl_pts[1] <= cfg_data;
        CFG_POINT_C:    ctrl_pts[2] <= cfg_data;
        CFG_POINT_D:    ctrl_pts[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  ccpe_basis #(.T_FRAC_BITS(T_FRAC_BITS)) u_basis (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_t      (s_axis_tdata[TW-1:0]),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_t     (b_t),
    .out_t2    (b_t2),
    .out_u2    (b_u2),
    .out_ut    (b_ut),
    .out_t3    (b_t3),
    .out_u3    (b_u3),
    .out_u2t   (b_u2t),
    .out_ut2   (b_ut2)
  );

  ccpe_weights #(.T_FRAC_BITS(T_FRAC_BITS)) u_weights (
    .clk       (clk),
    .rst       (rst),
    .mode      (curve_mode),
    .in_valid  (b_valid),
    .in_ready  (b_ready),
    .in_t      (b_t),
    .in_t2     (b_t2),
    .in_u2     (b_u2),
    .in_ut     (b_ut),
    .in_t3     (b_t3),
    .in_u3     (b_u3),
    .in_u2t    (b_u2t),
    .in_ut2    (b_ut2),
    .out_valid (w_valid),
    .out_ready (w_ready),
    .out_w     (w_val)
  );

  ccpe_blend #(.COORD_BITS(COORD_BITS), .T_FRAC_BITS(T_FRAC_BITS)) u_blend (
    .clk       (clk),
    .rst       (rst),
    .points    (ctrl_pts),
    .in_valid  (w_valid),
    .in_ready  (w_ready),
    .in_w      (w_val),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_x     (res_x),
    .out_y     (res_y),
    .out_z     (res_z),
    .out_sat   (res_sat)
  );

  assign m_axis_tdata = {res_z, res_y, res_x};
  assign m_axis_tuser = res_sat;

  // The input side only stalls when the whole pipeline is full and blocked.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while the output side can move");

  // Nothing leaves the pipeline in the first cycle after reset.
  a_empty_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule
